### rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RFP_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rfp assertion failed");

// Next-cycle implication, disabled during reset.
`define RFP_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rfp assertion failed");

`endif

### rtl/rfp_pkg.sv
// Package for the ranging frame parser: widths, constants, phase type, match struct.
// No dependencies.
`timescale 1ns / 1ps

package rfp_pkg;

  localparam int BYTE_W        = 8;
  localparam int ID_W          = 16;
  localparam int DIST_W        = 32;
  localparam int ANCHOR_IDX_W  = 2;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;
  localparam int COUNT_W       = 3;
  localparam int PAYLOAD_LEN   = 6;
  localparam int NUM_ANCHORS_DEF = 3;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFE;

  typedef enum logic [1:0] {
    PHASE_WAIT = 2'd0,
    PHASE_DATA = 2'd1,
    PHASE_SUM  = 2'd2
  } phase_t;

  typedef struct packed {
    logic                    hit;
    logic [ANCHOR_IDX_W-1:0] index;
  } match_t;

endpackage

### rtl/rfp_byte_if.sv
// Byte input channel: valid/ready with one received byte.
// Depends on rfp_pkg.
`timescale 1ns / 1ps

interface rfp_byte_if;
  logic                      valid;
  logic                      ready;
  logic [rfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/rfp_result_if.sv
// Result channel: valid/ready with anchor index and raw distance word.
// Depends on rfp_pkg.
`timescale 1ns / 1ps

interface rfp_result_if;
  logic                             valid;
  logic                             ready;
  logic [rfp_pkg::ANCHOR_IDX_W-1:0] anchor_index;
  logic [rfp_pkg::DIST_W-1:0]       distance_bits;

  modport source (output valid, output anchor_index, output distance_bits, input ready);
  modport sink   (input valid, input anchor_index, input distance_bits, output ready);
endinterface

### rtl/rfp_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on rfp_pkg.
`timescale 1ns / 1ps

interface rfp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rfp_pkg::CFG_IDX_W-1:0]  index;
  logic [rfp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/ranging_frame_parser_core.sv
// Ranging frame parser: sync byte, six payload bytes, 8-bit sum check, anchor id lookup.
// Result valid in the cycle after an accepted checksum byte passing sum and id checks.
// Throughput: one byte per cycle; a byte is taken while the result register is
// empty or being drained in the same cycle.
// Reset (sync, active high): phase to wait-for-sync, count and sum to zero,
// anchor ids to zero, result register empty.
`timescale 1ns / 1ps

module ranging_frame_parser_core #(
  parameter int NUM_ANCHORS = rfp_pkg::NUM_ANCHORS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rfp_byte_if.sink    rx,
  rfp_result_if.source result,
  rfp_cfg_if.sink     cfg
);

  logic [NUM_ANCHORS-1:0][rfp_pkg::ID_W-1:0] anchor_ids;

  rfp_pkg::phase_t               phase;
  rfp_pkg::phase_t               phase_next;
  logic [rfp_pkg::COUNT_W-1:0]   byte_count;
  logic [rfp_pkg::COUNT_W-1:0]   byte_count_next;
  logic [rfp_pkg::BYTE_W-1:0]    running_sum;
  logic [rfp_pkg::BYTE_W-1:0]    running_sum_next;
  logic [rfp_pkg::BYTE_W-1:0]    payload_store [rfp_pkg::PAYLOAD_LEN];
  logic                          store_en;
  logic                          emit;

  logic                          rx_fire;
  logic [rfp_pkg::ID_W-1:0]      frame_id;
  logic [rfp_pkg::DIST_W-1:0]    frame_dist;
  rfp_pkg::match_t               match;

  assign cfg.ready = 1'b1;
  assign rx.ready  = !result.valid || result.ready;
  assign rx_fire   = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_ids <= '0;
    end else if (cfg.valid && cfg.ready) begin
      for (int i = 0; i < NUM_ANCHORS; i++) begin
        if (cfg.index == rfp_pkg::CFG_IDX_W'(i)) begin
          anchor_ids[i] <= cfg.data;
        end
      end
    end
  end

  assign frame_id   = {payload_store[1], payload_store[0]};
  assign frame_dist = {payload_store[5], payload_store[4], payload_store[3], payload_store[2]};

  rfp_anchor_match #(
    .NUM_ANCHORS(NUM_ANCHORS)
  ) u_anchor_match (
    .anchor_ids(anchor_ids),
    .frame_id  (frame_id),
    .match     (match)
  );

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    store_en         = 1'b0;
    emit             = 1'b0;
    unique case (phase)
      rfp_pkg::PHASE_WAIT: begin
        if (rx.rx_byte == rfp_pkg::SYNC_BYTE) begin
          byte_count_next  = '0;
          running_sum_next = '0;
          phase_next       = rfp_pkg::PHASE_DATA;
        end
      end
      rfp_pkg::PHASE_DATA: begin
        if (byte_count < rfp_pkg::COUNT_W'(rfp_pkg::PAYLOAD_LEN)) begin
          store_en         = 1'b1;
          running_sum_next = running_sum + rx.rx_byte;
          byte_count_next  = byte_count + 1'b1;
        end
        if (byte_count_next >= rfp_pkg::COUNT_W'(rfp_pkg::PAYLOAD_LEN)) begin
          phase_next = rfp_pkg::PHASE_SUM;
        end
      end
      rfp_pkg::PHASE_SUM: begin
        emit       = (running_sum == rx.rx_byte) && match.hit;
        phase_next = rfp_pkg::PHASE_WAIT;
      end
      default: begin
        phase_next = rfp_pkg::PHASE_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= rfp_pkg::PHASE_WAIT;
      byte_count  <= '0;
      running_sum <= '0;
    end else if (rx_fire) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
    end
  end

  // payload bytes, no reset
  always_ff @(posedge clk) begin
    if (rx_fire && store_en) begin
      payload_store[byte_count] <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (rx_fire && emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_fire && emit) begin
      result.anchor_index  <= match.index;
      result.distance_bits <= frame_dist;
    end
  end

endmodule

### rtl/rfp_anchor_match.sv
// Compares the frame id with the configured anchor ids; lowest slot wins.
// Depends on rfp_pkg.
`timescale 1ns / 1ps

module rfp_anchor_match #(
  parameter int NUM_ANCHORS = rfp_pkg::NUM_ANCHORS_DEF
) (
  input  logic [NUM_ANCHORS-1:0][rfp_pkg::ID_W-1:0] anchor_ids,
  input  logic [rfp_pkg::ID_W-1:0]                  frame_id,
  output rfp_pkg::match_t                           match
);

  always_comb begin
    match = '0;
    for (int i = NUM_ANCHORS - 1; i >= 0; i--) begin
      if (anchor_ids[i] == frame_id) begin
        match.hit   = 1'b1;
        match.index = rfp_pkg::ANCHOR_IDX_W'(i);
      end
    end
  end

endmodule

### rtl/rfp_checker.sv
// Port-level checks for the ranging frame parser, bound to the top level.
// Depends on rfp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rfp_checker #(
  parameter int NUM_ANCHORS = rfp_pkg::NUM_ANCHORS_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             rx_valid,
  input logic                             rx_ready,
  input logic                             res_valid,
  input logic                             res_ready,
  input logic [rfp_pkg::ANCHOR_IDX_W-1:0] res_index,
  input logic [rfp_pkg::DIST_W-1:0]       res_dist
);

  `RFP_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_index) && $stable(res_dist))
  `RFP_ASSERT_IMP(a_res_index_range, clk, rst, res_valid, res_index < rfp_pkg::ANCHOR_IDX_W'(NUM_ANCHORS))
  `RFP_ASSERT_IMP(a_rx_ready_free, clk, rst, !res_valid || res_ready, rx_ready)
  `RFP_ASSERT_NXT(a_res_needs_byte, clk, rst, !res_valid || res_ready, !res_valid || $past(rx_valid && rx_ready))

endmodule

bind ranging_frame_parser_core rfp_checker #(
  .NUM_ANCHORS(NUM_ANCHORS)
) u_rfp_checker (
  .clk      (clk),
  .rst      (rst),
  .rx_valid (rx.valid),
  .rx_ready (rx.ready),
  .res_valid(result.valid),
  .res_ready(result.ready),
  .res_index(result.anchor_index),
  .res_dist (result.distance_bits)
);
